### hw/rtl/rtpn_pkg.sv
// ----------------------------------------------------------------------------
// rtpn_pkg
// Types and constants shared by the palette matching pipeline.
// ----------------------------------------------------------------------------
package rtpn_pkg;

  localparam int unsigned LEVEL_COUNT = 6;

  typedef logic [2:0]  level_t;
  typedef logic [4:0]  step_t;
  typedef logic [12:0] cube_dist_t;
  typedef logic [17:0] dist_t;

  localparam logic [7:0] CUBE_LEVEL [LEVEL_COUNT] = '{
    8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255
  };

  // highest value that still snaps to the lower of two neighbouring levels
  localparam logic [7:0] SNAP_LIMIT [LEVEL_COUNT-1] = '{
    8'd47, 8'd115, 8'd155, 8'd195, 8'd235
  };

  localparam logic [7:0]  CUBE_BASE     = 8'd16;
  localparam logic [7:0]  CUBE_R_STRIDE = 8'd36;
  localparam logic [7:0]  CUBE_G_STRIDE = 8'd6;
  localparam logic [7:0]  GREY_BASE     = 8'd232;
  localparam step_t       GREY_MAX_STEP = 5'd23;
  localparam logic [7:0]  GREY_OFFSET   = 8'd8;
  localparam logic [7:0]  GREY_SPACING  = 8'd10;
  localparam logic [7:0]  GREY_BIAS     = 8'd3;

  // reciprocal multipliers, both followed by a right shift of RECIP_SHIFT
  localparam logic [9:0]  DIV3_MUL      = 10'd683;
  localparam logic [7:0]  DIV10_MUL     = 8'd205;
  localparam int unsigned RECIP_SHIFT   = 11;

endpackage

### hw/rtl/rtpn_if.sv
// ----------------------------------------------------------------------------
// rtpn_in_if / rtpn_out_if
// Valid/ready channels carrying an rgb item and a palette index item.
// ----------------------------------------------------------------------------
interface rtpn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rtpn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] palette_index;

  modport source (output valid, output palette_index, input ready);
  modport sink   (input valid, input palette_index, output ready);
endinterface

### hw/rtl/rgb_to_palette256_nearest.sv
// ----------------------------------------------------------------------------
// rgb_to_palette256_nearest
// Nearest 256-colour palette entry for an 8-bit rgb item, five-stage pipeline.
// ----------------------------------------------------------------------------
// usage
//   in_ch  : valid/ready sink, one rgb item (red, green, blue) per handshake
//   out_ch : valid/ready source, one palette_index item per input item
//   rate   : one item per cycle unless stalled; every stage is registered
//            and the whole pipeline advances together, so each stage holds
//            one item
//   stages : 1 cube snap and channel sum, 2 cube distance and divide by three,
//            3 grey step, 4 grey level differences, 5 grey distance and choice
//   reset  : rst_n (synchronous, low) clears all stage valid bits; no other
//            state is kept between items
//   stall  : when the result waits with out_ch.ready low, every stage holds
//            and in_ch.ready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
module rgb_to_palette256_nearest (
  input  logic       clk,
  input  logic       rst_n,
  rtpn_in_if.sink    in_ch,
  rtpn_out_if.source out_ch
);
  import rtpn_pkg::*;

  localparam int unsigned STAGES = 5;

  logic [STAGES-1:0] vld_r;
  logic              advance;

  // stage 1
  logic [7:0] s1_red_r, s1_green_r, s1_blue_r;
  level_t     s1_lr_r, s1_lg_r, s1_lb_r;
  logic [5:0] s1_dr_r, s1_dg_r, s1_db_r;
  logic [9:0] s1_sum_r;
  level_t     lr_nxt, lg_nxt, lb_nxt;
  logic [5:0] dr_nxt, dg_nxt, db_nxt;

  // stage 2
  logic [7:0] s2_red_r, s2_green_r, s2_blue_r;
  logic [7:0] s2_cube_idx_r;
  cube_dist_t s2_cube_d_r;
  logic [7:0] s2_avg_r;
  dist_t      cube_d_full;
  logic [19:0] avg_prod;
  logic [7:0] cube_idx_nxt;

  // stage 3
  logic [7:0] s3_red_r, s3_green_r, s3_blue_r;
  logic [7:0] s3_cube_idx_r;
  cube_dist_t s3_cube_d_r;
  step_t      s3_step_r;
  step_t      step_nxt;

  // stage 4
  logic [7:0] s4_cube_idx_r;
  cube_dist_t s4_cube_d_r;
  step_t      s4_step_r;
  logic [7:0] s4_gdr_r, s4_gdg_r, s4_gdb_r;
  logic [7:0] grey_val;

  // stage 5
  logic [7:0] s5_idx_r;
  dist_t      grey_d;

  assign advance     = !vld_r[STAGES-1] || out_ch.ready;
  assign in_ch.ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[STAGES-2:0], in_ch.valid};
    end
  end

  rtpn_snap u_snap_r (.value(in_ch.red),   .level(lr_nxt), .diff(dr_nxt));
  rtpn_snap u_snap_g (.value(in_ch.green), .level(lg_nxt), .diff(dg_nxt));
  rtpn_snap u_snap_b (.value(in_ch.blue),  .level(lb_nxt), .diff(db_nxt));

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_red_r   <= in_ch.red;
      s1_green_r <= in_ch.green;
      s1_blue_r  <= in_ch.blue;
      s1_lr_r    <= lr_nxt;
      s1_lg_r    <= lg_nxt;
      s1_lb_r    <= lb_nxt;
      s1_dr_r    <= dr_nxt;
      s1_dg_r    <= dg_nxt;
      s1_db_r    <= db_nxt;
      s1_sum_r   <= 10'(in_ch.red) + 10'(in_ch.green) + 10'(in_ch.blue);
    end
  end

  rtpn_dist u_cube_dist (
    .diff_r(8'(s1_dr_r)),
    .diff_g(8'(s1_dg_r)),
    .diff_b(8'(s1_db_r)),
    .sq_sum(cube_d_full)
  );

  always_comb begin
    avg_prod     = 20'(s1_sum_r) * 20'(DIV3_MUL);
    cube_idx_nxt = 8'(CUBE_BASE + 8'(s1_lr_r) * CUBE_R_STRIDE
                   + 8'(s1_lg_r) * CUBE_G_STRIDE + 8'(s1_lb_r));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_red_r      <= s1_red_r;
      s2_green_r    <= s1_green_r;
      s2_blue_r     <= s1_blue_r;
      s2_cube_idx_r <= cube_idx_nxt;
      s2_cube_d_r   <= cube_d_full[12:0];
      s2_avg_r      <= avg_prod[RECIP_SHIFT +: 8];
    end
  end

  rtpn_grey_step u_grey_step (.avg(s2_avg_r), .step(step_nxt));

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_red_r      <= s2_red_r;
      s3_green_r    <= s2_green_r;
      s3_blue_r     <= s2_blue_r;
      s3_cube_idx_r <= s2_cube_idx_r;
      s3_cube_d_r   <= s2_cube_d_r;
      s3_step_r     <= step_nxt;
    end
  end

  assign grey_val = 8'(GREY_OFFSET + 8'(s3_step_r) * GREY_SPACING);

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_cube_idx_r <= s3_cube_idx_r;
      s4_cube_d_r   <= s3_cube_d_r;
      s4_step_r     <= s3_step_r;
      s4_gdr_r      <= (s3_red_r   >= grey_val) ? 8'(s3_red_r - grey_val)
                                                : 8'(grey_val - s3_red_r);
      s4_gdg_r      <= (s3_green_r >= grey_val) ? 8'(s3_green_r - grey_val)
                                                : 8'(grey_val - s3_green_r);
      s4_gdb_r      <= (s3_blue_r  >= grey_val) ? 8'(s3_blue_r - grey_val)
                                                : 8'(grey_val - s3_blue_r);
    end
  end

  rtpn_dist u_grey_dist (
    .diff_r(s4_gdr_r),
    .diff_g(s4_gdg_r),
    .diff_b(s4_gdb_r),
    .sq_sum(grey_d)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      if (grey_d < 18'(s4_cube_d_r)) begin
        s5_idx_r <= 8'(GREY_BASE + 8'(s4_step_r));
      end else begin
        s5_idx_r <= s4_cube_idx_r;
      end
    end
  end

  assign out_ch.valid         = vld_r[STAGES-1];
  assign out_ch.palette_index = s5_idx_r;

endmodule

### hw/rtl/rtpn_snap.sv
// ----------------------------------------------------------------------------
// rtpn_snap
// Snaps one channel to its nearest cube level, lower level on a tie.
// ----------------------------------------------------------------------------
module rtpn_snap (
  input  logic [7:0]      value,
  output rtpn_pkg::level_t level,
  output logic [5:0]      diff
);
  import rtpn_pkg::*;

  logic [7:0] lvl_val;

  always_comb begin
    if (value <= SNAP_LIMIT[0]) begin
      level = 3'd0;
    end else if (value <= SNAP_LIMIT[1]) begin
      level = 3'd1;
    end else if (value <= SNAP_LIMIT[2]) begin
      level = 3'd2;
    end else if (value <= SNAP_LIMIT[3]) begin
      level = 3'd3;
    end else if (value <= SNAP_LIMIT[4]) begin
      level = 3'd4;
    end else begin
      level = 3'd5;
    end
  end

  always_comb begin
    lvl_val = CUBE_LEVEL[level];
    if (value >= lvl_val) begin
      diff = 6'(value - lvl_val);
    end else begin
      diff = 6'(lvl_val - value);
    end
  end

endmodule

### hw/rtl/rtpn_grey_step.sv
// ----------------------------------------------------------------------------
// rtpn_grey_step
// Grey ramp step from the channel average, rounded and clamped.
// ----------------------------------------------------------------------------
module rtpn_grey_step (
  input  logic [7:0]      avg,
  output rtpn_pkg::step_t step
);
  import rtpn_pkg::*;

  logic [7:0]  biased;
  logic [15:0] prod;
  step_t       raw;

  always_comb begin
    biased = 8'(avg - GREY_BIAS);
    prod   = 16'(biased) * 16'(DIV10_MUL);
    raw    = prod[RECIP_SHIFT +: 5];
    if (avg < GREY_BIAS) begin
      step = '0;
    end else if (raw > GREY_MAX_STEP) begin
      step = GREY_MAX_STEP;
    end else begin
      step = raw;
    end
  end

endmodule

### hw/rtl/rtpn_dist.sv
// ----------------------------------------------------------------------------
// rtpn_dist
// Squared rgb distance from three per-channel absolute differences.
// ----------------------------------------------------------------------------
module rtpn_dist (
  input  logic [7:0]      diff_r,
  input  logic [7:0]      diff_g,
  input  logic [7:0]      diff_b,
  output rtpn_pkg::dist_t sq_sum
);
  import rtpn_pkg::*;

  logic [15:0] sq_r;
  logic [15:0] sq_g;
  logic [15:0] sq_b;

  always_comb begin
    sq_r   = 16'(diff_r) * 16'(diff_r);
    sq_g   = 16'(diff_g) * 16'(diff_g);
    sq_b   = 16'(diff_b) * 16'(diff_b);
    sq_sum = 18'(sq_r) + 18'(sq_g) + 18'(sq_b);
  end

endmodule

### hw/rtl/rtpn_checker.sv
// ----------------------------------------------------------------------------
// rtpn_checker
// Port-level checks on the palette matching pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module rtpn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_idx
);

  // a waiting result item holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_idx))
    else $error("result item changed while stalled");

  // no entry of the low sixteen system colours is ever produced
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_idx >= 8'd16)
    else $error("palette index below colour cube");

  // the pipeline only holds its input back while a result is stalled
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == !(out_valid && !out_ready))
    else $error("input ready does not follow output stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present after reset");

  // an accepted item comes out of the last stage when no stall comes between
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 in_ready ##1 in_ready ##1 in_ready ##1 in_ready
    |=> out_valid)
    else $error("result item missing after pipeline latency");

endmodule

bind rgb_to_palette256_nearest rtpn_checker u_rtpn_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_idx  (out_ch.palette_index)
);
